FILE: src/bgh_pkg.sv
// ----------------------------------------------------------------------------
// bgh_pkg
// Shared types and codes for the bimodal / skewed global hybrid predictor.
// ----------------------------------------------------------------------------
package bgh_pkg;

  typedef enum logic [2:0] {
    KIND_LOOKUP  = 3'd0,
    KIND_UNCOND  = 3'd1,
    KIND_RESOLVE = 3'd2,
    KIND_RESTORE = 3'd3,
    KIND_BTB_MISS = 3'd4
  } kind_e;

  localparam int unsigned AddrBits = 48;
  localparam int unsigned SnapBits = 16;

  typedef struct packed {
    logic [2:0]          kind;
    logic [AddrBits-1:0] pc;
    logic [2:0]          slot;
    logic                only_local;
    logic                outcome_taken;
    logic                was_squashed;
    logic [SnapBits-1:0] saved_history;
    logic                saved_local_pred;
    logic                saved_global_pred;
    logic                saved_global_used;
    logic [2:0]          saved_votes;
    logic                saved_valid;
  } item_t;

  // handshake between the queue and the execution side
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage

FILE: src/bgh_front.sv
// ----------------------------------------------------------------------------
// bgh_front
// Request intake: a two-entry queue that decouples acceptance from execution.
// ----------------------------------------------------------------------------
module bgh_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bgh_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output bgh_pkg::item_t item_o
);
  import bgh_pkg::*;

  item_t       buf_q [2];
  logic        wptr_q, wptr_d;
  logic        rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = buf_q[rptr_q];
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= item_i;
    end
  end

endmodule

FILE: src/bgh_back.sv
// ----------------------------------------------------------------------------
// bgh_back
// Execution side: counter tables, speculative history, lookup and training.
// ----------------------------------------------------------------------------
module bgh_back #(
  parameter int unsigned LOCAL_ENTRIES  = 4096,
  parameter int unsigned GLOBAL_ENTRIES = 4096,
  parameter int unsigned COUNTER_BITS   = 2,
  parameter int unsigned HISTORY_BITS   = 12,
  parameter int unsigned SKEW_ROTATE_0  = 2,
  parameter int unsigned SKEW_ROTATE_1  = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         inst_shift_i,
  input  logic [1:0]         fetch_width_log2_i,
  input  logic               empty_i,
  input  bgh_pkg::item_t     item_i,
  output bgh_pkg::back_ctl_t ctl_o,
  output logic               valid_o,
  output logic               prediction_o,
  output logic               global_used_o,
  output logic               local_pred_o,
  output logic               vote_pred_o,
  output logic [2:0]         votes_o,
  output logic [15:0]        history_snapshot_o,
  output logic               indices_valid_o
);
  import bgh_pkg::*;

  localparam int unsigned LIW   = $clog2(LOCAL_ENTRIES);
  localparam int unsigned GIW   = $clog2(GLOBAL_ENTRIES);
  localparam int unsigned MAXE  = (LOCAL_ENTRIES > GLOBAL_ENTRIES) ? LOCAL_ENTRIES
                                                                   : GLOBAL_ENTRIES;
  localparam int unsigned CLRW  = $clog2(MAXE);
  localparam int unsigned HB    = HISTORY_BITS;
  localparam int unsigned ROT0  = SKEW_ROTATE_0 % HISTORY_BITS;
  localparam int unsigned ROT1  = SKEW_ROTATE_1 % HISTORY_BITS;
  localparam int unsigned CB    = COUNTER_BITS;
  localparam logic [LIW-1:0] LMASK = LIW'(LOCAL_ENTRIES - 1);
  localparam logic [GIW-1:0] GMASK = GIW'(GLOBAL_ENTRIES - 1);
  localparam logic [CB-1:0]  CMAX  = {CB{1'b1}};

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_INDEX = 5'b00100,
    S_READ  = 5'b01000,
    S_EXEC  = 5'b10000
  } state_e;

  function automatic logic [AddrBits-1:0] form_idx(input logic [AddrBits-1:0] addr,
                                                   input logic [2:0] slot,
                                                   input logic [HB-1:0] h,
                                                   input logic [1:0] ishift,
                                                   input logic [2:0] gshift);
    logic [AddrBits-1:0] v;
    v = (addr >> gshift) ^ AddrBits'(h);
    return (v << ishift) + AddrBits'(slot);
  endfunction

  function automatic logic [HB-1:0] rot(input logic [HB-1:0] h, input int unsigned r);
    return (h >> r) | (h << (HB - r));
  endfunction

  function automatic logic [CB-1:0] train(input logic [CB-1:0] c, input logic up);
    logic [CB-1:0] n;
    n = c;
    if (up && c != CMAX) n = c + 1'b1;
    if (!up && c != '0) n = c - 1'b1;
    return n;
  endfunction

  state_e state_q, state_d;
  logic [CLRW-1:0] clr_q;
  logic [HB-1:0]   hist_q, hist_d;
  item_t           it_q;
  logic [LIW-1:0]  li_q;
  logic [GIW-1:0]  i0_q, i1_q, ci_q;
  logic [CB-1:0]   bim_rd_q, s0_rd_q, s1_rd_q, ch_rd_q;
  logic [CB-1:0]   bim_mem [LOCAL_ENTRIES];
  logic [CB-1:0]   s0_mem  [GLOBAL_ENTRIES];
  logic [CB-1:0]   s1_mem  [GLOBAL_ENTRIES];
  logic [CB-1:0]   ch_mem  [GLOBAL_ENTRIES];

  logic [HB-1:0]   idx_h, sh;
  logic [2:0]      gshift;
  logic            clr_last;
  logic            is_lookup, is_resolve;

  // execute stage signals
  logic            l, g0, g1, maj, ch, p, hpred, tv;
  logic [CB-1:0]   cc;
  logic            bim_we, s0_we, s1_we, ch_we, ch_up;
  logic [CB-1:0]   bim_wd, s0_wd, s1_wd, ch_wd;
  logic [LIW-1:0]  bim_wa;
  logic [GIW-1:0]  s0_wa, s1_wa, ch_wa;
  logic            ex_bim, ex_s0, ex_s1, ex_ch;

  assign gshift     = {1'b0, inst_shift_i} + {1'b0, fetch_width_log2_i};
  assign sh         = it_q.saved_history[HB-1:0];
  assign is_lookup  = (it_q.kind == KIND_LOOKUP);
  assign is_resolve = (it_q.kind == KIND_RESOLVE);
  assign idx_h      = is_lookup ? hist_q : sh;
  assign clr_last   = (clr_q == CLRW'(MAXE - 1));

  assign ctl_o.pop      = (state_q == S_IDLE) & ~empty_i;
  assign ctl_o.clearing = (state_q == S_CLEAR);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_last) state_d = S_IDLE;
      S_IDLE:  if (!empty_i) state_d = S_INDEX;
      S_INDEX: state_d = S_READ;
      S_READ:  state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---- decision and training
  always_comb begin
    l     = bim_rd_q[CB-1];
    g0    = s0_rd_q[CB-1];
    g1    = s1_rd_q[CB-1];
    maj   = (l & g0) | (l & g1) | (g0 & g1);
    cc    = ch_rd_q;
    if (it_q.only_local) cc = (ch_rd_q > CB'(1)) ? ch_rd_q - CB'(2) : '0;
    ch    = cc[CB-1];
    p     = ch ? maj : l;
    hpred = it_q.saved_global_used ? it_q.saved_global_pred : it_q.saved_local_pred;

    ex_bim = 1'b0;
    ex_s0  = 1'b0;
    ex_s1  = 1'b0;
    ex_ch  = 1'b0;
    ch_up  = 1'b0;
    tv     = 1'b0;
    if (is_resolve && it_q.saved_valid) begin
      if (!it_q.was_squashed) begin
        ex_ch = it_q.saved_local_pred != it_q.saved_global_pred;
        ch_up = it_q.saved_global_used;
        if (!it_q.saved_global_used) ex_bim = 1'b1;
        else tv = 1'b1;
      end else if (hpred != it_q.outcome_taken) begin
        if (it_q.saved_local_pred == it_q.saved_global_pred) begin
          ex_s0  = 1'b1;
          ex_s1  = 1'b1;
          ex_bim = 1'b1;
        end else begin
          ex_ch = 1'b1;
          ch_up = ~it_q.saved_global_used;
          if (it_q.saved_global_used) ex_bim = 1'b1;
          else tv = 1'b1;
        end
      end
      if (tv) begin
        ex_s0  = it_q.saved_votes[1];
        ex_s1  = it_q.saved_votes[2];
        ex_bim = it_q.saved_votes[0];
      end
    end

    hist_d = hist_q;
    unique case (it_q.kind)
      KIND_LOOKUP:   hist_d = {hist_q[HB-2:0], p};
      KIND_UNCOND:   hist_d = {hist_q[HB-2:0], 1'b1};
      KIND_RESOLVE:  if (it_q.was_squashed) hist_d = {sh[HB-2:0], it_q.outcome_taken};
      KIND_RESTORE:  hist_d = sh;
      KIND_BTB_MISS: hist_d = {hist_q[HB-1:1], 1'b0};
      default:       hist_d = hist_q;
    endcase
  end

  // write port muxing: clearing pass or execute
  always_comb begin
    if (state_q == S_CLEAR) begin
      bim_we = ({1'b0, clr_q} < (CLRW+1)'(LOCAL_ENTRIES));
      s0_we  = ({1'b0, clr_q} < (CLRW+1)'(GLOBAL_ENTRIES));
      s1_we  = s0_we;
      ch_we  = s0_we;
      bim_wa = clr_q[LIW-1:0];
      s0_wa  = clr_q[GIW-1:0];
      s1_wa  = clr_q[GIW-1:0];
      ch_wa  = clr_q[GIW-1:0];
      bim_wd = '0;
      s0_wd  = '0;
      s1_wd  = '0;
      ch_wd  = '0;
    end else begin
      bim_we = (state_q == S_EXEC) & ex_bim;
      s0_we  = (state_q == S_EXEC) & ex_s0;
      s1_we  = (state_q == S_EXEC) & ex_s1;
      ch_we  = (state_q == S_EXEC) & (ex_ch | (is_lookup & it_q.only_local));
      bim_wa = li_q;
      s0_wa  = i0_q;
      s1_wa  = i1_q;
      ch_wa  = ci_q;
      bim_wd = train(bim_rd_q, it_q.outcome_taken);
      s0_wd  = train(s0_rd_q, it_q.outcome_taken);
      s1_wd  = train(s1_rd_q, it_q.outcome_taken);
      ch_wd  = is_lookup ? cc : train(ch_rd_q, ch_up);
    end
  end

  always_ff @(posedge clk_i) begin
    if (bim_we) bim_mem[bim_wa] <= bim_wd;
    if (state_q == S_READ) bim_rd_q <= bim_mem[li_q];
  end

  always_ff @(posedge clk_i) begin
    if (s0_we) s0_mem[s0_wa] <= s0_wd;
    if (state_q == S_READ) s0_rd_q <= s0_mem[i0_q];
  end

  always_ff @(posedge clk_i) begin
    if (s1_we) s1_mem[s1_wa] <= s1_wd;
    if (state_q == S_READ) s1_rd_q <= s1_mem[i1_q];
  end

  always_ff @(posedge clk_i) begin
    if (ch_we) ch_mem[ch_wa] <= ch_wd;
    if (state_q == S_READ) ch_rd_q <= ch_mem[ci_q];
  end

  // item capture and index forming
  always_ff @(posedge clk_i) begin
    if (ctl_o.pop) it_q <= item_i;
    if (state_q == S_INDEX) begin
      li_q <= LIW'(form_idx(it_q.pc, it_q.slot, '0, inst_shift_i, gshift)) & LMASK;
      i0_q <= GIW'(form_idx(it_q.pc, it_q.slot, rot(idx_h, ROT0), inst_shift_i, gshift))
              & GMASK;
      i1_q <= GIW'(form_idx(it_q.pc, it_q.slot, rot(idx_h, ROT1), inst_shift_i, gshift))
              & GMASK;
      ci_q <= GIW'(form_idx(it_q.pc, it_q.slot, idx_h, inst_shift_i, gshift)) & GMASK;
    end
    if (state_q == S_EXEC) begin
      history_snapshot_o <= 16'(hist_q);
      indices_valid_o    <= is_lookup;
      prediction_o       <= is_lookup ? p   : (it_q.kind == KIND_UNCOND);
      global_used_o      <= is_lookup ? ch  : (it_q.kind == KIND_UNCOND);
      local_pred_o       <= is_lookup ? l   : (it_q.kind == KIND_UNCOND);
      vote_pred_o        <= is_lookup ? maj : (it_q.kind == KIND_UNCOND);
      votes_o            <= is_lookup ? {g1 == maj, g0 == maj, l == maj} : 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      hist_q  <= '0;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == S_EXEC) hist_q <= hist_d;
      valid_o <= (state_q == S_EXEC);
    end
  end

endmodule

FILE: src/bimodal_gskew_hybrid_branch_predictor.sv
// result: when the block is idle, valid_o rises after the index, read and execute states
// sequencing: requests run the index/read/execute sequence one at a time; the
//   two-entry queue holds later ones (history must settle before the next request)
// reset: history and control clear at once; a clearing pass over max(LOCAL_ENTRIES,
//   GLOBAL_ENTRIES) entries zeroes the tables, busy stays high meanwhile
// results are strobed by valid_o for one cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
// bimodal_gskew_hybrid_branch_predictor
// Hybrid bimodal / skewed-global branch predictor with a choice table.
// ----------------------------------------------------------------------------
module bimodal_gskew_hybrid_branch_predictor #(
  parameter int unsigned LOCAL_ENTRIES  = 4096,
  parameter int unsigned GLOBAL_ENTRIES = 4096,
  parameter int unsigned COUNTER_BITS   = 2,
  parameter int unsigned HISTORY_BITS   = 12,
  parameter int unsigned SKEW_ROTATE_0  = 2,
  parameter int unsigned SKEW_ROTATE_1  = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [1:0]  cfg_data_i,
  input  logic [2:0]  kind_i,
  input  logic [47:0] pc_i,
  input  logic [2:0]  slot_i,
  input  logic        only_local_i,
  input  logic        outcome_taken_i,
  input  logic        was_squashed_i,
  input  logic [15:0] saved_history_i,
  input  logic        saved_local_pred_i,
  input  logic        saved_global_pred_i,
  input  logic        saved_global_used_i,
  input  logic [2:0]  saved_votes_i,
  input  logic        saved_valid_i,
  output logic        valid_o,
  output logic        prediction_o,
  output logic        global_used_o,
  output logic        local_pred_o,
  output logic        vote_pred_o,
  output logic [2:0]  votes_o,
  output logic [15:0] history_snapshot_o,
  output logic        indices_valid_o
);
  import bgh_pkg::*;

  localparam logic CFG_INST_SHIFT = 1'b0;
  localparam logic CFG_FETCH_LOG2 = 1'b1;

  logic [1:0] inst_shift_q, fetch_log2_q;
  item_t      in_item, q_item;
  back_ctl_t  ctl;
  logic       q_full, q_empty, push;

  assign busy = q_full | ctl.clearing;
  assign push = start & ~busy;

  assign in_item = '{kind: kind_i, pc: pc_i, slot: slot_i,
                     only_local: only_local_i, outcome_taken: outcome_taken_i,
                     was_squashed: was_squashed_i, saved_history: saved_history_i,
                     saved_local_pred: saved_local_pred_i,
                     saved_global_pred: saved_global_pred_i,
                     saved_global_used: saved_global_used_i,
                     saved_votes: saved_votes_i, saved_valid: saved_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inst_shift_q <= 2'd2;
      fetch_log2_q <= 2'd2;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_INST_SHIFT) inst_shift_q <= cfg_data_i;
      if (cfg_idx_i == CFG_FETCH_LOG2) fetch_log2_q <= cfg_data_i;
    end
  end

  bgh_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .pop_i   (ctl.pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  bgh_back #(
    .LOCAL_ENTRIES  (LOCAL_ENTRIES),
    .GLOBAL_ENTRIES (GLOBAL_ENTRIES),
    .COUNTER_BITS   (COUNTER_BITS),
    .HISTORY_BITS   (HISTORY_BITS),
    .SKEW_ROTATE_0  (SKEW_ROTATE_0),
    .SKEW_ROTATE_1  (SKEW_ROTATE_1)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .inst_shift_i       (inst_shift_q),
    .fetch_width_log2_i (fetch_log2_q),
    .empty_i            (q_empty),
    .item_i             (q_item),
    .ctl_o              (ctl),
    .valid_o            (valid_o),
    .prediction_o       (prediction_o),
    .global_used_o      (global_used_o),
    .local_pred_o       (local_pred_o),
    .vote_pred_o        (vote_pred_o),
    .votes_o            (votes_o),
    .history_snapshot_o (history_snapshot_o),
    .indices_valid_o    (indices_valid_o)
  );

endmodule

FILE: src/bgh_checker.sv
// ----------------------------------------------------------------------------
// bgh_checker
// Port-level checks on the predictor's result stream.
// ----------------------------------------------------------------------------
module bgh_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_o,
  input logic       prediction_o,
  input logic       global_used_o,
  input logic       local_pred_o,
  input logic       vote_pred_o,
  input logic [2:0] votes_o,
  input logic       indices_valid_o
);

  // one request is executed at a time, so strobes never touch
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("back-to-back result strobes");

  a_pred_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && indices_valid_o |->
      prediction_o == (global_used_o ? vote_pred_o : local_pred_o))
    else $error("prediction does not follow choice");

  a_no_votes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !indices_valid_o |-> votes_o == 3'd0)
    else $error("votes on a request without indices");

  a_uncond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !indices_valid_o && global_used_o |->
      prediction_o && local_pred_o && vote_pred_o)
    else $error("unconditional result not all taken");

endmodule

bind bimodal_gskew_hybrid_branch_predictor bgh_checker u_bgh_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_o         (valid_o),
  .prediction_o    (prediction_o),
  .global_used_o   (global_used_o),
  .local_pred_o    (local_pred_o),
  .vote_pred_o     (vote_pred_o),
  .votes_o         (votes_o),
  .indices_valid_o (indices_valid_o)
);
